>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks that report by $error; empty when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising edge outside reset
`define ASSERT_AT(lbl, clk_s, rstn, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk_s, rstn, expr, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk_s, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk_s, rstn, expr, msg)

`endif

`endif

>>> design/ffr_pkg.sv
// ----------------------------------------------------------------------------
// ffr_pkg
// Types and fixed constants of the frame flip and rotate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ffr_pkg;

	localparam int DIM_W      = 11;
	localparam int MODE_W     = 2;
	localparam int HDR_W      = 16;
	localparam int PIX_W      = 8;
	localparam int PAD_W      = 2;
	localparam int BYTES_W    = 22;
	localparam int ROWB_W     = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int RGB_W      = 3 * PIX_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSFORM_MODE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_OFFSET  = 2'd3;

	// transform modes
	localparam logic [MODE_W-1:0] MODE_MIRROR  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FLIP    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ROT_CW  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ROT_CCW = 2'd3;

	// word kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// register reset values
	localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 11'd1;
	localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 11'd1;
	localparam logic [MODE_W-1:0] RST_MODE         = MODE_MIRROR;
	localparam logic [HDR_W-1:0]  RST_HEADER       = 16'd54;

	// cycles the derived geometry needs after a register write
	localparam logic [1:0] SETTLE_CYCLES = 2'd3;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	typedef struct packed {
		logic             kind;
		logic [PIX_W-1:0] red_in;
		logic [PIX_W-1:0] green_in;
		logic [PIX_W-1:0] blue_in;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0]   red_out;
		logic [PIX_W-1:0]   green_out;
		logic [PIX_W-1:0]   blue_out;
		logic               last_pixel;
		logic [DIM_W-1:0]   out_width;
		logic [DIM_W-1:0]   out_height;
		logic [PAD_W-1:0]   row_padding;
		logic [BYTES_W-1:0] image_bytes;
		logic [BYTES_W-1:0] file_bytes;
		logic               error_flag;
	} rsp_t;

	// what travels with a word from the access stage to the queue
	typedef struct packed {
		logic res;
		logic rd;
		logic err;
		logic last;
	} tag_t;

endpackage

`default_nettype wire

>>> design/ffr_ram.sv
// ----------------------------------------------------------------------------
// ffr_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                        wdata,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

>>> design/frame_flip_rotate_unit.sv
// Pipeline: a read word passes the s1 stage (frame store read), the s2 stage and the
//   result queue before its result shows on rsp; a load is written to the store from s1.
// Throughput: one word per cycle while rsp drains, set by the single frame store port.
// A register write, and reset, hold req_ready low until the derived geometry has settled.
// Reset: arst_n clears counters, read position, pipeline and result queue at once;
//   the frame store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// frame_flip_rotate_unit
// Frame store for RGB pixels that loads in raster order and reads back the
// frame mirrored, flipped or turned a quarter turn, with bitmap geometry.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_flip_rotate_unit #(
	parameter int MAX_PIXELS = 65536,
	parameter int MAX_DIM    = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ffr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ffr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  ffr_pkg::req_t                    req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output ffr_pkg::rsp_t                    rsp
);

	// store address and load counter widths follow the store depth
	localparam int ADDR_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CNT_W   = $clog2(MAX_PIXELS + 1);
	// read position width follows the largest side, capped at the field width
	localparam int POS_RAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int POS_W   = (POS_RAW > ffr_pkg::DIM_W) ? ffr_pkg::DIM_W : POS_RAW;
	localparam int AREA_W  = 2 * ffr_pkg::DIM_W;
	localparam int IMGF_W  = ffr_pkg::ROWB_W + ffr_pkg::DIM_W;
	localparam logic [AREA_W-1:0]        AREA_MAX = AREA_W'(MAX_PIXELS);
	localparam logic [ffr_pkg::DIM_W+1:0] DIM_MAX = (ffr_pkg::DIM_W + 2)'(MAX_DIM);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [ffr_pkg::DIM_W-1:0]  width_q;
	logic [ffr_pkg::DIM_W-1:0]  height_q;
	logic [ffr_pkg::MODE_W-1:0] mode_q;
	logic [ffr_pkg::HDR_W-1:0]  hdr_q;
	logic [1:0]                 settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ffr_pkg::RST_FRAME_WIDTH;
			height_q <= ffr_pkg::RST_FRAME_HEIGHT;
			mode_q   <= ffr_pkg::RST_MODE;
			hdr_q    <= ffr_pkg::RST_HEADER;
		end else if (cfg_we) begin
			case (cfg_index)
				ffr_pkg::REG_FRAME_WIDTH:    width_q  <= cfg_data[ffr_pkg::DIM_W-1:0];
				ffr_pkg::REG_FRAME_HEIGHT:   height_q <= cfg_data[ffr_pkg::DIM_W-1:0];
				ffr_pkg::REG_TRANSFORM_MODE: mode_q   <= cfg_data[ffr_pkg::MODE_W-1:0];
				ffr_pkg::REG_HEADER_OFFSET:  hdr_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold off words until the derived geometry below has caught up with the
	// registers: three register stages sit between a write and file_q.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= ffr_pkg::SETTLE_CYCLES;
		end else if (cfg_we) begin
			settle_q <= ffr_pkg::SETTLE_CYCLES;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	// ------------------------------------------------------------------
	// Derived geometry, recomputed every cycle from the registers
	// ------------------------------------------------------------------
	logic                        rot;
	logic [ffr_pkg::DIM_W-1:0]   ow_c, oh_c;
	logic [ffr_pkg::DIM_W-1:0]   ow_q, oh_q;
	logic [ffr_pkg::PAD_W-1:0]   pad_q;
	logic [ffr_pkg::ROWB_W-1:0]  row_bytes_q;
	logic [AREA_W-1:0]           area_c, area_q;
	logic                        dims_ok_q;
	logic                        frame_ok_c, frame_ok_q;
	logic [CNT_W-1:0]            total_q;
	logic [IMGF_W-1:0]           img_full_c;
	logic [ffr_pkg::BYTES_W-1:0] img_q, file_q;

	assign rot  = (mode_q == ffr_pkg::MODE_ROT_CW) || (mode_q == ffr_pkg::MODE_ROT_CCW);
	assign ow_c = rot ? height_q : width_q;
	assign oh_c = rot ? width_q : height_q;
	assign area_c = AREA_W'(width_q) * AREA_W'(height_q);

	// first stage: output sides, padding, padded row bytes, input area, side check
	always_ff @(posedge clk) begin
		ow_q  <= ow_c;
		oh_q  <= oh_c;
		// (4 - 3w mod 4) mod 4 reduces to w mod 4
		pad_q <= ow_c[ffr_pkg::PAD_W-1:0];
		row_bytes_q <= {2'b00, ow_c} + {1'b0, ow_c, 1'b0}
			+ ffr_pkg::ROWB_W'(ow_c[ffr_pkg::PAD_W-1:0]);
		area_q    <= area_c;
		dims_ok_q <= (width_q != '0) && (height_q != '0)
			&& ({2'b00, width_q} <= DIM_MAX) && ({2'b00, height_q} <= DIM_MAX);
	end

	assign frame_ok_c = dims_ok_q && (area_q <= AREA_MAX);
	assign img_full_c = IMGF_W'(row_bytes_q) * IMGF_W'(oh_q);

	// second stage: frame check, pixel count, image bytes; third: file bytes
	always_ff @(posedge clk) begin
		frame_ok_q <= frame_ok_c;
		total_q    <= frame_ok_c ? area_q[CNT_W-1:0] : '0;
		img_q      <= img_full_c[ffr_pkg::BYTES_W-1:0];
		file_q     <= img_q + ffr_pkg::BYTES_W'(hdr_q);
	end

	// ------------------------------------------------------------------
	// Access stage: decode the word, move the counters, form the address
	// ------------------------------------------------------------------
	logic                       accept;
	logic                       is_read;
	logic                       load_ok, read_ok;
	logic [CNT_W-1:0]           load_cnt_q;
	logic [POS_W-1:0]           row_q, col_q;
	logic [ffr_pkg::DIM_W-1:0]  row_x, col_x;
	logic                       row_last, col_last;
	logic [ffr_pkg::DIM_W-1:0]  src_row, src_col;
	logic [AREA_W-1:0]          src_c;
	logic                       pop;
	logic [3:0]                 pending;
	ffr_pkg::tag_t              tag_s1, tag_s2;
	logic [ffr_pkg::FIFO_CNT_W-1:0] fifo_cnt_q;

	assign accept  = req_valid && req_ready;
	assign is_read = (req.kind == ffr_pkg::KIND_READ);
	assign row_x   = ffr_pkg::DIM_W'(row_q);
	assign col_x   = ffr_pkg::DIM_W'(col_q);
	assign row_last = (row_x == oh_q - ffr_pkg::DIM_W'(1));
	assign col_last = (col_x == ow_q - ffr_pkg::DIM_W'(1));

	assign load_ok = frame_ok_q && (load_cnt_q < total_q);
	assign read_ok = frame_ok_q && (load_cnt_q == total_q) && (row_x < oh_q) && (col_x < ow_q);

	// source pixel = src_row * width + src_col
	always_comb begin
		case (mode_q)
			ffr_pkg::MODE_MIRROR: begin
				src_row = row_x;
				src_col = width_q - ffr_pkg::DIM_W'(1) - col_x;
			end
			ffr_pkg::MODE_FLIP: begin
				src_row = height_q - ffr_pkg::DIM_W'(1) - row_x;
				src_col = col_x;
			end
			ffr_pkg::MODE_ROT_CW: begin
				src_row = height_q - ffr_pkg::DIM_W'(1) - col_x;
				src_col = row_x;
			end
			default: begin
				src_row = col_x;
				src_col = width_q - ffr_pkg::DIM_W'(1) - row_x;
			end
		endcase
	end

	assign src_c = AREA_W'(src_row) * AREA_W'(width_q) + AREA_W'(src_col);

	// Take a word only when its result, and every result still in flight,
	// is sure of a queue slot.
	always_comb begin
		pending   = 4'(fifo_cnt_q) + 4'(tag_s1.res) + 4'(tag_s2.res);
		req_ready = (settle_q == 2'd0) && !cfg_we
			&& (pending <= 4'(ffr_pkg::FIFO_DEPTH - 1) + 4'(pop));
	end

	// load counter and read position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			row_q      <= '0;
			col_q      <= '0;
		end else if (cfg_we) begin
			// any write restarts the read-out; a new size drops the loaded frame
			row_q <= '0;
			col_q <= '0;
			if (cfg_index == ffr_pkg::REG_FRAME_WIDTH || cfg_index == ffr_pkg::REG_FRAME_HEIGHT) begin
				load_cnt_q <= '0;
			end
		end else if (accept) begin
			if (!is_read) begin
				if (load_ok) begin
					load_cnt_q <= load_cnt_q + CNT_W'(1);
				end
			end else if (read_ok) begin
				if (row_last && col_last) begin
					// frame done: wrap and open the store for the next frame
					row_q      <= '0;
					col_q      <= '0;
					load_cnt_q <= '0;
				end else if (col_last) begin
					col_q <= '0;
					row_q <= row_q + POS_W'(1);
				end else begin
					col_q <= col_q + POS_W'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Store stage s1: frame store write or read
	// ------------------------------------------------------------------
	logic                       we_s1;
	logic [ADDR_W-1:0]          addr_s1;
	logic [ffr_pkg::RGB_W-1:0]  wdata_s1;
	logic [ffr_pkg::RGB_W-1:0]  rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s1  <= 1'b0;
			tag_s1 <= '0;
		end else begin
			we_s1  <= accept && !is_read && load_ok;
			tag_s1.res  <= accept && (is_read || !load_ok);
			tag_s1.rd   <= accept && is_read && read_ok;
			tag_s1.err  <= accept && (is_read ? !read_ok : !load_ok);
			tag_s1.last <= accept && is_read && read_ok && row_last && col_last;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1  <= is_read ? src_c[ADDR_W-1:0] : load_cnt_q[ADDR_W-1:0];
		wdata_s1 <= {req.red_in, req.green_in, req.blue_in};
	end

	ffr_ram #(
		.WIDTH(ffr_pkg::RGB_W),
		.DEPTH(MAX_PIXELS)
	) u_store (
		.clk  (clk),
		.we   (we_s1),
		.addr (addr_s1),
		.wdata(wdata_s1),
		.rdata(rdata)
	);

	// ------------------------------------------------------------------
	// Stage s2: join read data with geometry and push into the queue
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	ffr_pkg::rsp_t                 entry_c;
	ffr_pkg::rsp_t                 fifo_q [ffr_pkg::FIFO_DEPTH];
	logic [ffr_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic                          push;

	always_comb begin
		entry_c.red_out     = tag_s2.rd ? rdata[23:16] : '0;
		entry_c.green_out   = tag_s2.rd ? rdata[15:8]  : '0;
		entry_c.blue_out    = tag_s2.rd ? rdata[7:0]   : '0;
		entry_c.last_pixel  = tag_s2.last;
		entry_c.out_width   = ow_q;
		entry_c.out_height  = oh_q;
		entry_c.row_padding = pad_q;
		entry_c.image_bytes = img_q;
		entry_c.file_bytes  = file_q;
		entry_c.error_flag  = tag_s2.err;
	end

	assign push      = tag_s2.res;
	assign rsp_valid = (fifo_cnt_q != '0);
	assign rsp       = fifo_q[rd_ptr_q];
	assign pop       = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ffr_pkg::FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ffr_pkg::FIFO_PTR_W'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + ffr_pkg::FIFO_CNT_W'(push) - ffr_pkg::FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry_c;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
`include "assert_macros.svh"

	// a result reaching the queue always finds a free slot
	`ASSERT_AT(a_queue_room, clk, arst_n, push |-> (fifo_cnt_q < ffr_pkg::FIFO_CNT_W'(ffr_pkg::FIFO_DEPTH)) || pop, "result pushed into full queue")
	// loading never runs past the frame size once geometry has settled
	`ASSERT_AT(a_load_bound, clk, arst_n, (settle_q == 2'd0) |-> (load_cnt_q <= total_q), "load count beyond frame size")
	// a store write and a result never share the store stage
	`ASSERT_NEVER(a_port_clash, clk, arst_n, we_s1 && tag_s1.res, "store write and result in one slot")
	// the final pixel word is never an error word
	`ASSERT_NEVER(a_last_err, clk, arst_n, rsp_valid && rsp.last_pixel && rsp.error_flag, "last pixel flagged as error")

endmodule

`default_nettype wire
